FILE: rtl/core/bfgr_pkg.sv
// ============================================================================
// Bitmap font glyph row generator package
// Request codes, register indexes and fixed widths shared by the design.
// ============================================================================
package bfgr_pkg;

  localparam int REQ_W      = 2;
  localparam int CODE_W     = 8;
  localparam int MADDR_W    = 16;
  localparam int WVAL_W     = 16;
  localparam int ROW_W      = 64;
  localparam int ROWNUM_W   = 6;
  localparam int GWIDTH_W   = 7;
  localparam int HEIGHT_W   = 7;
  localparam int OFFSET_W   = 16;
  localparam int BYTE_W     = 8;
  localparam int BYTE_IDX_W = 3;
  localparam int NBYTES_W   = 4;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REQ_W-1:0] REQ_WRITE_WIDTH  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WRITE_OFFSET = 2'd1;
  localparam logic [REQ_W-1:0] REQ_WRITE_BYTE   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_RENDER       = 2'd3;

  localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_CODE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_LAST_CODE    = 2'd2;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd8;
  localparam logic [CODE_W-1:0]   FIRST_RESET  = 8'd0;
  localparam logic [CODE_W-1:0]   LAST_RESET   = 8'd255;

endpackage

FILE: rtl/core/bitmap_font_glyph_row_generator_top.sv
// ============================================================================
// Bitmap font glyph row generator
// Character generator for a column-major raster bitmap font with width,
// offset and bitmap stores and a row-by-row render engine.
// ============================================================================
// Width, offset and bitmap-byte write beats are each accepted while the
// engine is idle. A render beat emits H rows, where H is the saturated glyph
// height, and reads B = ceil(width / 8) bitmap bytes per row (B = 0 for an
// empty glyph) through the single read port of the bitmap memory, one byte
// per cycle. The block takes one beat at a time and accepts the next
// beat as soon as the last row of a render sits in the output register.
// BITMAP_BYTES must be a power of two.
// The width table has a valid bit per code, so it reads as zero until
// written; no clearing pass is needed after reset.
module bitmap_font_glyph_row_generator_top #(
  parameter int BITMAP_BYTES = 65536,
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int NUM_CODES    = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [bfgr_pkg::REQ_W-1:0]        in_req_type,
  input  logic [bfgr_pkg::CODE_W-1:0]       in_char_code,
  input  logic [bfgr_pkg::MADDR_W-1:0]      in_mem_address,
  input  logic [bfgr_pkg::WVAL_W-1:0]       in_write_value,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [bfgr_pkg::ROW_W-1:0]        out_row_bits,
  output logic [bfgr_pkg::ROWNUM_W-1:0]     out_row_number,
  output logic [bfgr_pkg::GWIDTH_W-1:0]     out_glyph_width,
  output logic                              out_empty_glyph,
  output logic                              out_last_row,

  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bfgr_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bfgr_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bfgr_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int ADDR_W = $clog2(BITMAP_BYTES);
  localparam int CIDX_W = $clog2(NUM_CODES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_ISSUE = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  // Configuration registers.
  logic [bfgr_pkg::HEIGHT_W-1:0]  cfg_height_r;
  logic [bfgr_pkg::CODE_W-1:0]    cfg_first_r;
  logic [bfgr_pkg::CODE_W-1:0]    cfg_last_r;
  logic                           cfg_wr;
  logic [bfgr_pkg::REG_IDX_W-1:0] cfg_idx;

  // Stores.
  logic [bfgr_pkg::GWIDTH_W-1:0]  width_mem [NUM_CODES];
  logic [NUM_CODES-1:0]           width_vld_r;
  logic [bfgr_pkg::OFFSET_W-1:0]  offset_mem [NUM_CODES];
  logic [bfgr_pkg::BYTE_W-1:0]    bitmap_mem [BITMAP_BYTES];

  logic [bfgr_pkg::GWIDTH_W-1:0]  width_rd_r;
  logic                           width_vld_rd_r;
  logic [bfgr_pkg::OFFSET_W-1:0]  offset_rd_r;
  logic [bfgr_pkg::BYTE_W-1:0]    bm_rd_r;

  // Engine state.
  logic [1:0]                     state_r, state_nxt;
  logic [bfgr_pkg::CODE_W-1:0]    code_r;
  logic [bfgr_pkg::HEIGHT_W-1:0]  height_r;
  logic [bfgr_pkg::GWIDTH_W-1:0]  width_r;
  logic                           empty_r;
  logic [bfgr_pkg::ROW_W-1:0]     mask_r;
  logic [bfgr_pkg::NBYTES_W-1:0]  nbytes_r;
  logic [bfgr_pkg::NBYTES_W-1:0]  iss_r;
  logic                           pend_r;
  logic [bfgr_pkg::BYTE_IDX_W-1:0] pend_idx_r;
  logic [bfgr_pkg::ROWNUM_W-1:0]  row_r;
  logic [ADDR_W-1:0]              row_base_r;
  logic [ADDR_W-1:0]              col_addr_r;
  logic [bfgr_pkg::ROW_W-1:0]     acc_r;

  logic                           out_valid_r;
  logic [bfgr_pkg::ROW_W-1:0]     out_row_bits_r;
  logic [bfgr_pkg::ROWNUM_W-1:0]  out_row_number_r;
  logic [bfgr_pkg::GWIDTH_W-1:0]  out_glyph_width_r;
  logic                           out_empty_glyph_r;
  logic                           out_last_row_r;

  logic                           in_acc;
  logic                           out_acc;
  logic                           emit_go;
  logic                           last_now;
  logic                           issue;
  logic [bfgr_pkg::HEIGHT_W-1:0]  height_sat;
  logic                           code_ok;
  logic                           look_empty;
  logic [bfgr_pkg::GWIDTH_W-1:0]  look_width;
  logic [bfgr_pkg::GWIDTH_W-1:0]  width_round;
  logic [bfgr_pkg::GWIDTH_W-1:0]  width_sat;
  logic [bfgr_pkg::BYTE_W-1:0]    byte_rev;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign emit_go   = (state_r == S_EMIT) && (!out_valid_r || !out_stall);
  assign last_now  = ({1'b0, row_r} + 7'd1) == height_r;
  assign issue     = (state_r == S_ISSUE) && (iss_r < nbytes_r);

  assign height_sat = (cfg_height_r > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : cfg_height_r;
  assign width_sat  = (in_write_value > 16'(MAX_WIDTH)) ? 7'(MAX_WIDTH)
                                                        : in_write_value[6:0];

  assign code_ok    = ({1'b0, code_r} < 9'(NUM_CODES)) && (code_r >= cfg_first_r)
                      && (code_r <= cfg_last_r);
  assign look_empty = !(code_ok && width_vld_rd_r && (width_rd_r != '0));
  assign look_width = look_empty ? 7'd1 : width_rd_r;
  assign width_round = look_width + 7'd7;

  always_comb begin
    for (int k = 0; k < bfgr_pkg::BYTE_W; k++) begin
      byte_rev[k] = bm_rd_r[bfgr_pkg::BYTE_W-1-k];
    end
  end

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_idx)
      bfgr_pkg::REG_GLYPH_HEIGHT: cfg_prdata = 32'(cfg_height_r);
      bfgr_pkg::REG_FIRST_CODE:   cfg_prdata = 32'(cfg_first_r);
      bfgr_pkg::REG_LAST_CODE:    cfg_prdata = 32'(cfg_last_r);
      default:                    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_height_r <= bfgr_pkg::HEIGHT_RESET;
      cfg_first_r  <= bfgr_pkg::FIRST_RESET;
      cfg_last_r   <= bfgr_pkg::LAST_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        bfgr_pkg::REG_GLYPH_HEIGHT: cfg_height_r <= cfg_pwdata[6:0];
        bfgr_pkg::REG_FIRST_CODE:   cfg_first_r  <= cfg_pwdata[7:0];
        bfgr_pkg::REG_LAST_CODE:    cfg_last_r   <= cfg_pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Table memories.
  always_ff @(posedge clk) begin
    if (in_acc && (in_req_type == bfgr_pkg::REQ_WRITE_WIDTH)
        && ({1'b0, in_char_code} < 9'(NUM_CODES))) begin
      width_mem[in_char_code[CIDX_W-1:0]] <= width_sat;
    end
    if (in_acc && (in_req_type == bfgr_pkg::REQ_WRITE_OFFSET)
        && ({1'b0, in_char_code} < 9'(NUM_CODES))) begin
      offset_mem[in_char_code[CIDX_W-1:0]] <= in_write_value;
    end
    if (in_acc && (in_req_type == bfgr_pkg::REQ_RENDER)) begin
      width_rd_r     <= width_mem[in_char_code[CIDX_W-1:0]];
      width_vld_rd_r <= width_vld_r[in_char_code[CIDX_W-1:0]];
      offset_rd_r    <= offset_mem[in_char_code[CIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_vld_r <= '0;
    end else if (in_acc && (in_req_type == bfgr_pkg::REQ_WRITE_WIDTH)
                 && ({1'b0, in_char_code} < 9'(NUM_CODES))) begin
      width_vld_r[in_char_code[CIDX_W-1:0]] <= 1'b1;
    end
  end

  // Bitmap memory.
  always_ff @(posedge clk) begin
    if (in_acc && (in_req_type == bfgr_pkg::REQ_WRITE_BYTE)) begin
      bitmap_mem[ADDR_W'(in_mem_address)] <= in_write_value[7:0];
    end
    if (issue) begin
      bm_rd_r <= bitmap_mem[col_addr_r];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && (in_req_type == bfgr_pkg::REQ_RENDER) && (height_sat != '0)) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK:  state_nxt = S_ISSUE;
      S_ISSUE: begin
        if (iss_r == nbytes_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_go) begin
          state_nxt = last_now ? S_IDLE : S_ISSUE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      code_r   <= in_char_code;
      height_r <= height_sat;
      row_r    <= '0;
    end
    if (state_r == S_LOOK) begin
      empty_r    <= look_empty;
      width_r    <= look_width;
      nbytes_r   <= look_empty ? '0 : width_round[6:3];
      mask_r     <= (look_width >= 7'(bfgr_pkg::ROW_W)) ? '1
                    : ((64'(1) << look_width) - 64'(1));
      row_base_r <= ADDR_W'(offset_rd_r);
      col_addr_r <= ADDR_W'(offset_rd_r);
      iss_r      <= '0;
      acc_r      <= '0;
    end
    if (issue) begin
      iss_r      <= iss_r + 4'd1;
      col_addr_r <= col_addr_r + ADDR_W'(height_r);
      pend_idx_r <= iss_r[bfgr_pkg::BYTE_IDX_W-1:0];
    end
    if (pend_r) begin
      acc_r[{pend_idx_r, 3'b000} +: bfgr_pkg::BYTE_W] <= byte_rev;
    end
    if (emit_go && !last_now) begin
      row_r      <= row_r + 6'd1;
      row_base_r <= row_base_r + ADDR_W'(1);
      col_addr_r <= row_base_r + ADDR_W'(1);
      iss_r      <= '0;
      acc_r      <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= issue;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_acc) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_row_bits_r    <= acc_r & mask_r;
      out_row_number_r  <= row_r;
      out_glyph_width_r <= width_r;
      out_empty_glyph_r <= empty_r;
      out_last_row_r    <= last_now;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_row_bits    = out_row_bits_r;
  assign out_row_number  = out_row_number_r;
  assign out_glyph_width = out_glyph_width_r;
  assign out_empty_glyph = out_empty_glyph_r;
  assign out_last_row    = out_last_row_r;

  // Assertions.
  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> ({1'b0, row_r} < height_r))
    else $error("row index beyond glyph height");

  a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> ({1'b0, pend_idx_r} < nbytes_r))
    else $error("bitmap byte returned for a column beyond the glyph");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_go && last_now) |=> (state_r == S_IDLE) && out_valid_r && out_last_row_r)
    else $error("last row did not end the render");

  a_empty_rows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_glyph_r) |->
      (out_row_bits_r == '0) && (out_glyph_width_r == 7'd1))
    else $error("empty glyph row carries pixels");

  a_no_issue_empty: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_ISSUE) && empty_r) |-> !issue)
    else $error("bitmap read issued for an empty glyph");

endmodule
